### design/atilt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atilt_pkg
// Shared types, constants and the microcode program of the tilt angle block.
// ----------------------------------------------------------------------------
package atilt_pkg;

  localparam int PC_W = 5;

  localparam logic [15:0] TILT_NUM = 16'd18000;
  localparam logic [15:0] TILT_DEN = 16'd314;

  // root loop runs 16 steps, each divide loop 6 steps
  localparam logic [3:0] SQRT_LAST = 4'd15;
  localparam logic [3:0] DIV_LAST  = 4'd5;
  localparam logic [31:0] SQRT_TOP_BIT = 32'h4000_0000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_Z,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_MUL_DEN,
    OP_MUL_NUMX,
    OP_MUL_NUMY,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_STORE_X,
    OP_STORE_Y,
    OP_RESULT,
    OP_RESULT_HELD
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_WAIT_IN,
    COND_LOOP,
    COND_ZERO,
    COND_WAIT_OUT
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic root_zero;
  } status_t;

  // program step addresses
  localparam logic [PC_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] ST_SQX   = 5'd1;
  localparam logic [PC_W-1:0] ST_SQY   = 5'd2;
  localparam logic [PC_W-1:0] ST_SQZ   = 5'd3;
  localparam logic [PC_W-1:0] ST_RINIT = 5'd4;
  localparam logic [PC_W-1:0] ST_RSTEP = 5'd5;
  localparam logic [PC_W-1:0] ST_CHK   = 5'd6;
  localparam logic [PC_W-1:0] ST_DEN   = 5'd7;
  localparam logic [PC_W-1:0] ST_NUMX  = 5'd8;
  localparam logic [PC_W-1:0] ST_DINX  = 5'd9;
  localparam logic [PC_W-1:0] ST_DSTX  = 5'd10;
  localparam logic [PC_W-1:0] ST_STX   = 5'd11;
  localparam logic [PC_W-1:0] ST_NUMY  = 5'd12;
  localparam logic [PC_W-1:0] ST_DINY  = 5'd13;
  localparam logic [PC_W-1:0] ST_DSTY  = 5'd14;
  localparam logic [PC_W-1:0] ST_STY   = 5'd15;
  localparam logic [PC_W-1:0] ST_OUT   = 5'd16;
  localparam logic [PC_W-1:0] ST_HOLD  = 5'd17;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NOP, cond: COND_ALWAYS, target: ST_IDLE};
    unique case (pc)
      ST_IDLE:  c = '{op: OP_NOP,         cond: COND_WAIT_IN,  target: ST_SQX};
      ST_SQX:   c = '{op: OP_SQ_X,        cond: COND_NEXT,     target: ST_IDLE};
      ST_SQY:   c = '{op: OP_SQ_Y,        cond: COND_NEXT,     target: ST_IDLE};
      ST_SQZ:   c = '{op: OP_SQ_Z,        cond: COND_NEXT,     target: ST_IDLE};
      ST_RINIT: c = '{op: OP_SQRT_INIT,   cond: COND_NEXT,     target: ST_IDLE};
      ST_RSTEP: c = '{op: OP_SQRT_STEP,   cond: COND_LOOP,     target: ST_RSTEP};
      ST_CHK:   c = '{op: OP_NOP,         cond: COND_ZERO,     target: ST_HOLD};
      ST_DEN:   c = '{op: OP_MUL_DEN,     cond: COND_NEXT,     target: ST_IDLE};
      ST_NUMX:  c = '{op: OP_MUL_NUMX,    cond: COND_NEXT,     target: ST_IDLE};
      ST_DINX:  c = '{op: OP_DIV_INIT,    cond: COND_NEXT,     target: ST_IDLE};
      ST_DSTX:  c = '{op: OP_DIV_STEP,    cond: COND_LOOP,     target: ST_DSTX};
      ST_STX:   c = '{op: OP_STORE_X,     cond: COND_NEXT,     target: ST_IDLE};
      ST_NUMY:  c = '{op: OP_MUL_NUMY,    cond: COND_NEXT,     target: ST_IDLE};
      ST_DINY:  c = '{op: OP_DIV_INIT,    cond: COND_NEXT,     target: ST_IDLE};
      ST_DSTY:  c = '{op: OP_DIV_STEP,    cond: COND_LOOP,     target: ST_DSTY};
      ST_STY:   c = '{op: OP_STORE_Y,     cond: COND_NEXT,     target: ST_IDLE};
      ST_OUT:   c = '{op: OP_RESULT,      cond: COND_WAIT_OUT, target: ST_IDLE};
      ST_HOLD:  c = '{op: OP_RESULT_HELD, cond: COND_WAIT_OUT, target: ST_IDLE};
      default:  c = '{op: OP_NOP,         cond: COND_ALWAYS,   target: ST_IDLE};
    endcase
    return c;
  endfunction

endpackage

### design/atilt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atilt_seq
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module atilt_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     out_free,
  input  atilt_pkg::status_t       status,
  output atilt_pkg::ctrl_t         ctrl,
  output logic                     idle
);

  logic [atilt_pkg::PC_W-1:0] pc;
  logic [atilt_pkg::PC_W-1:0] pc_next;
  logic [atilt_pkg::PC_W-1:0] pc_inc;

  assign ctrl   = atilt_pkg::ucode(pc);
  assign idle   = (pc == atilt_pkg::ST_IDLE);
  assign pc_inc = atilt_pkg::PC_W'(pc + 1'b1);

  always_comb begin
    pc_next = pc_inc;
    unique case (ctrl.cond)
      atilt_pkg::COND_NEXT:     pc_next = pc_inc;
      atilt_pkg::COND_ALWAYS:   pc_next = ctrl.target;
      atilt_pkg::COND_WAIT_IN:  pc_next = start ? ctrl.target : pc;
      atilt_pkg::COND_LOOP:     pc_next = status.cnt_zero ? pc_inc : ctrl.target;
      atilt_pkg::COND_ZERO:     pc_next = status.root_zero ? ctrl.target : pc_inc;
      atilt_pkg::COND_WAIT_OUT: pc_next = out_free ? ctrl.target : pc;
      default:                  pc_next = atilt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= atilt_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### design/atilt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atilt_dp
// Datapath: shared multiplier, root step, divide step and angle state.
// ----------------------------------------------------------------------------
module atilt_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic signed [15:0]       accel_x,
  input  logic signed [15:0]       accel_y,
  input  logic signed [15:0]       accel_z,
  input  atilt_pkg::ctrl_t         ctrl,
  output atilt_pkg::status_t       status,
  output logic signed [6:0]        last_x,
  output logic signed [6:0]        last_y
);

  logic [15:0] ax, ay, az;
  logic        sx, sy;
  logic [31:0] acc;
  logic [31:0] root;
  logic [31:0] bitv;
  logic [24:0] den;
  logic [29:0] rem;
  logic [29:0] dsh;
  logic [5:0]  quo;
  logic [3:0]  cnt;

  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;
  logic [32:0] trial;
  logic        take;
  logic        dtake;
  logic [6:0]  q7;
  logic [6:0]  angle;
  logic        sgn;

  // abs of a 16-bit two's complement value fits 16 unsigned bits
  function automatic logic [15:0] abs16(input logic [15:0] v);
    return v[15] ? 16'(~v + 16'd1) : v;
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      atilt_pkg::OP_SQ_X:     begin mul_a = ax;        mul_b = ax; end
      atilt_pkg::OP_SQ_Y:     begin mul_a = ay;        mul_b = ay; end
      atilt_pkg::OP_SQ_Z:     begin mul_a = az;        mul_b = az; end
      atilt_pkg::OP_MUL_DEN:  begin mul_a = root[15:0]; mul_b = atilt_pkg::TILT_DEN; end
      atilt_pkg::OP_MUL_NUMX: begin mul_a = ax;        mul_b = atilt_pkg::TILT_NUM; end
      atilt_pkg::OP_MUL_NUMY: begin mul_a = ay;        mul_b = atilt_pkg::TILT_NUM; end
      default:                begin mul_a = '0;        mul_b = '0; end
    endcase
  end

  assign prod  = {16'd0, mul_a} * {16'd0, mul_b};
  assign trial = {1'b0, root} + {1'b0, bitv};
  assign take  = ({1'b0, acc} >= trial);
  assign dtake = (rem >= dsh);

  assign q7    = {1'b0, quo};
  assign sgn   = (ctrl.op == atilt_pkg::OP_STORE_X) ? sx : sy;
  assign angle = sgn ? 7'(~q7 + 7'd1) : q7;

  assign status.cnt_zero  = (cnt == '0);
  assign status.root_zero = (root == '0);

  always_ff @(posedge clk) begin
    if (load) begin
      ax <= abs16(accel_x);
      ay <= abs16(accel_y);
      az <= abs16(accel_z);
      sx <= accel_x[15];
      sy <= accel_y[15];
    end
    case (ctrl.op)
      atilt_pkg::OP_SQ_X:      acc <= prod;
      // sum of three squares stays below 2^32
      atilt_pkg::OP_SQ_Y,
      atilt_pkg::OP_SQ_Z:      acc <= acc + prod;
      atilt_pkg::OP_SQRT_INIT: begin
        root <= '0;
        bitv <= atilt_pkg::SQRT_TOP_BIT;
        cnt  <= atilt_pkg::SQRT_LAST;
      end
      atilt_pkg::OP_SQRT_STEP: begin
        if (take) begin
          acc  <= 32'(acc - trial[31:0]);
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 4'd1;
      end
      atilt_pkg::OP_MUL_DEN:   den <= prod[24:0];
      atilt_pkg::OP_MUL_NUMX,
      atilt_pkg::OP_MUL_NUMY:  rem <= prod[29:0];
      atilt_pkg::OP_DIV_INIT: begin
        // quotient is at most 57, so six bits cover it
        dsh <= {den, 5'd0};
        quo <= '0;
        cnt <= atilt_pkg::DIV_LAST;
      end
      atilt_pkg::OP_DIV_STEP: begin
        if (dtake) begin
          rem <= rem - dsh;
        end
        quo <= {quo[4:0], dtake};
        dsh <= dsh >> 1;
        cnt <= cnt - 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
    end else if (ctrl.op == atilt_pkg::OP_STORE_X) begin
      last_x <= angle;
    end else if (ctrl.op == atilt_pkg::OP_STORE_Y) begin
      last_y <= angle;
    end
  end

endmodule

### design/accel_tilt_angle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angle_top
// Tilt angles from one three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with accel_x, accel_y, accel_z (signed).
// Output channel: out_valid/out_ready with angle_x, angle_y (signed, -57..57)
// and held. One result per sample, in order.
// The magnitude is the floor square root of the sum of squares; each angle
// is axis*18000 / (magnitude*314) truncated toward zero. An all-zero sample
// repeats the last angles with held set.
// A microcoded sequencer steps one shared multiplier, a radix-4 root unit
// and a restoring divider. A sample runs through the three squares, the
// 16-step root loop and the zero check; unless the sample is all zero, a
// denominator multiply and, per axis, a multiply, a 6-step divide loop and
// a store follow. A new sample is taken only once the sequencer is idle.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; the next sample is accepted and worked on while it
// waits, and the sequencer holds at its last step if the register is still
// full. Reset clears the sequencer, the output valid and the stored angles.
// ----------------------------------------------------------------------------
module accel_tilt_angle_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [6:0]  angle_x,
  output logic signed [6:0]  angle_y,
  output logic               held
);

  atilt_pkg::ctrl_t   ctrl;
  atilt_pkg::status_t status;
  logic               in_fire;
  logic               out_free;
  logic               out_load;
  logic signed [6:0]  last_x;
  logic signed [6:0]  last_y;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && ((ctrl.op == atilt_pkg::OP_RESULT) ||
                                 (ctrl.op == atilt_pkg::OP_RESULT_HELD));

  atilt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl),
    .idle     (in_ready)
  );

  atilt_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .load    (in_fire),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .ctrl    (ctrl),
    .status  (status),
    .last_x  (last_x),
    .last_y  (last_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      angle_x <= last_x;
      angle_y <= last_y;
      held    <= (ctrl.op == atilt_pkg::OP_RESULT_HELD);
    end
  end

  // sequencer is busy right after taking a sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("sample accepted while sequencer stayed idle");

  // every result lies within the linear angle range
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_x >= -7'sd57) && (angle_x <= 7'sd57) &&
                  (angle_y >= -7'sd57) && (angle_y <= 7'sd57))
    else $error("angle out of range");

  // a freshly loaded result carries the stored angles
  a_load_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (angle_x == $past(last_x)) && (angle_y == $past(last_y)))
    else $error("result does not match stored angles");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the accelerometer tilt angle block.
// ----------------------------------------------------------------------------
// A driver sends three-axis samples from a queue, with random gaps between
// transactions. A monitor takes results under random back pressure. Each
// accepted sample is run through a tilt predictor that keeps its own copy of
// the last angles. Each result is checked field by field against the oldest
// expected angle set. The stimulus starts with a directed set of extremes and
// zero samples and goes on with random samples of mixed shape.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD  = 12;
  localparam int N_RANDOM    = 1950;
  localparam int WDOG_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 64;
  localparam int TILT_SCALE  = 18000;
  localparam int TILT_DIV    = 314;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } sample_t;

  typedef struct {
    logic signed [6:0] ax;
    logic signed [6:0] ay;
    logic              held;
  } tilt_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] accel_x = '0;
  logic signed [15:0] accel_y = '0;
  logic signed [15:0] accel_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [6:0]  angle_x;
  logic signed [6:0]  angle_y;
  logic               held;

  sample_t   sample_q[$];
  tilt_res_t tilt_expect_q[$];

  // predictor copy of the stored angles
  logic signed [6:0] last_tilt_x = '0;
  logic signed [6:0] last_tilt_y = '0;

  int err_cnt     = 0;
  int in_gap      = 0;
  int out_stall   = 0;
  int in_cnt      = 0;
  int out_cnt     = 0;
  int idle_cycles = 0;
  bit in_burst    = 1'b0;
  bit out_burst   = 1'b0;

  accel_tilt_angle_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_x   (angle_x),
    .angle_y   (angle_y),
    .held      (held)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bit_w;
    rem   = n;
    root  = 0;
    bit_w = 64'd1 << 32;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem  = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [6:0] axis_tilt(input logic signed [15:0] axis,
                                                 input int mag);
    int a;
    int a_abs;
    int q;
    a     = axis;
    a_abs = (a < 0) ? -a : a;
    q     = (a_abs * TILT_SCALE) / (mag * TILT_DIV);
    if (a < 0) begin
      q = -q;
    end
    return 7'(q);
  endfunction

  task automatic predict_tilt(input sample_t s);
    longint unsigned sum_sq;
    longint signed   vx;
    longint signed   vy;
    longint signed   vz;
    int              mag;
    tilt_res_t       r;
    vx     = s.x;
    vy     = s.y;
    vz     = s.z;
    sum_sq = vx * vx + vy * vy + vz * vz;
    mag    = int'(floor_root(sum_sq));
    if (mag == 0) begin
      r.held = 1'b1;
    end else begin
      last_tilt_x = axis_tilt(s.x, mag);
      last_tilt_y = axis_tilt(s.y, mag);
      r.held      = 1'b0;
    end
    r.ax = last_tilt_x;
    r.ay = last_tilt_y;
    tilt_expect_q.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic add_sample(input int x, input int y, input int z);
    sample_t s;
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    sample_q.push_back(s);
  endtask

  function automatic logic signed [15:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd1;
      4: return 16'sh8001;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] small_value();
    return 16'($urandom_range(0, 8)) - 16'd4;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      pick;
    pick = $urandom_range(0, 99);
    s.x  = 16'($urandom);
    s.y  = 16'($urandom);
    s.z  = 16'($urandom);
    if (pick < 4) begin
      s.x = '0;
      s.y = '0;
      s.z = '0;
    end else if (pick < 45) begin
      // full range, keep as drawn
    end else if (pick < 60) begin
      s.x = small_value();
      s.y = small_value();
      s.z = small_value();
    end else if (pick < 75) begin
      s.x = small_value();
      s.y = small_value();
      s.z = small_value();
      case ($urandom_range(0, 2))
        0: s.x = edge_value();
        1: s.y = edge_value();
        default: s.z = edge_value();
      endcase
    end else if (pick < 88) begin
      case ($urandom_range(0, 2))
        0: s.x = '0;
        1: s.y = '0;
        default: s.z = '0;
      endcase
    end else begin
      s.x = edge_value();
      s.y = edge_value();
      s.z = edge_value();
    end
    return s;
  endfunction

  // driver: one transaction at a time, gap drawn after each acceptance
  always @(posedge clk) begin
    bit      nxt_valid;
    sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap    = $urandom_range(0, 11);
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        s.x = accel_x;
        s.y = accel_y;
        s.z = accel_z;
        predict_tilt(s);
        in_cnt++;
        if (in_cnt % 64 == 0) begin
          in_burst = ($urandom_range(0, 3) == 0);
        end
        nxt_valid = 1'b0;
        in_gap    = in_burst ? 0 : $urandom_range(0, 11);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
        end else if (sample_q.size() > 0) begin
          s = sample_q.pop_front();
          accel_x   <= s.x;
          accel_y   <= s.y;
          accel_z   <= s.z;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor: compare each result transaction with the oldest expected angles
  always @(posedge clk) begin
    tilt_res_t e;
    bit        nxt_ready;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall  = $urandom_range(0, 11);
    end else begin
      nxt_ready = out_ready;
      if (out_valid && out_ready) begin
        out_cnt++;
        if (tilt_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%0d y=%0d held=%0b",
                                    angle_x, angle_y, held));
        end else begin
          e = tilt_expect_q.pop_front();
          if (angle_x !== e.ax) begin
            report_mismatch($sformatf("result %0d angle_x got %0d want %0d",
                                      out_cnt, angle_x, e.ax));
          end
          if (angle_y !== e.ay) begin
            report_mismatch($sformatf("result %0d angle_y got %0d want %0d",
                                      out_cnt, angle_y, e.ay));
          end
          if (held !== e.held) begin
            report_mismatch($sformatf("result %0d held got %0b want %0b",
                                      out_cnt, held, e.held));
          end
        end
        if (out_cnt % 64 == 0) begin
          out_burst = ($urandom_range(0, 3) == 0);
        end
        out_stall = out_burst ? 0 : $urandom_range(0, 11);
        nxt_ready = (out_stall == 0);
      end else if (out_stall > 0) begin
        out_stall = out_stall - 1;
        nxt_ready = (out_stall == 0);
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // held with reset angles, then axis extremes
    add_sample(0, 0, 0);
    add_sample(32767, 0, 0);
    add_sample(-32768, 0, 0);
    add_sample(0, 32767, 0);
    add_sample(0, -32768, 0);
    add_sample(0, 0, 32767);
    add_sample(0, 0, -32768);
    // zero after a nonzero sample repeats the last angles
    add_sample(0, 0, 0);
    add_sample(-32768, -32768, -32768);
    add_sample(32767, 32767, 32767);
    add_sample(32767, -32768, 0);
    add_sample(-32768, 32767, 1);
    add_sample(1, 0, 0);
    add_sample(0, -1, 0);
    add_sample(0, 0, 1);
    add_sample(-1, -1, -1);
    add_sample(0, 0, 0);
    add_sample(16'h5555, 16'haaaa, 16'h5555);
    add_sample(16'haaaa, 16'h5555, 16'haaaa);
    add_sample(1, 1, 32767);
    add_sample(-1, 1, -32768);
    add_sample(0, 0, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      sample_q.push_back(random_sample());
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (sample_q.size() > 0 || in_valid || tilt_expect_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0 && tilt_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/atilt_pkg.sv
design/atilt_seq.sv
design/atilt_dp.sv
design/accel_tilt_angle_top.sv
tb/sv/tb.sv
